### sv/rrv_pkg.sv
// ----------------------------------------------------------------------------
// rrv_pkg
// Shared widths and the request and status words of the serial arithmetic
// units of the rolling return volatility core.
// ----------------------------------------------------------------------------
package rrv_pkg;

    localparam int PRICE_W = 32;
    localparam int RET_W   = 32;
    localparam int VOL_W   = 31;
    localparam int WLEN_W  = 7;
    localparam int DIV_W   = 64;
    localparam int DVSR_W  = 32;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;

    typedef enum logic {
        ERR_NONE       = 1'b0,
        ERR_ZERO_PRICE = 1'b1
    } t_err;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] rem_init;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_sts;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [DVSR_W-1:0] root;
    } t_sqrt_sts;

endpackage

### sv/rrv_in_if.sv
// ----------------------------------------------------------------------------
// rrv_in_if
// Price channel: one word carries one Q16.16 price.
// ----------------------------------------------------------------------------
interface rrv_in_if;
    logic                          valid;
    logic                          ready;
    logic [rrv_pkg::PRICE_W-1:0]   price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

### sv/rrv_out_if.sv
// ----------------------------------------------------------------------------
// rrv_out_if
// Result channel: return, window mean, volatility and error code.
// ----------------------------------------------------------------------------
interface rrv_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rrv_pkg::RET_W-1:0]   latest_return;
    logic signed [rrv_pkg::RET_W-1:0]   window_mean;
    logic [rrv_pkg::VOL_W-1:0]          volatility;
    logic                               error_code;

    modport source (output valid, output latest_return, output window_mean,
                    output volatility, output error_code, input ready);
    modport sink   (input valid, input latest_return, input window_mean,
                    input volatility, input error_code, output ready);
endinterface

### sv/rrv_cfg_if.sv
// ----------------------------------------------------------------------------
// rrv_cfg_if
// Configuration write channel: one word sets the window length.
// ----------------------------------------------------------------------------
interface rrv_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rrv_pkg::WLEN_W-1:0]    window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

### sv/rrv_div.sv
// ----------------------------------------------------------------------------
// rrv_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrv_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrv_pkg::t_div_req i_req,
    output rrv_pkg::t_div_sts o_sts
);
    localparam int CNT_W = $clog2(rrv_pkg::DIV_W + 1);

    logic [rrv_pkg::DIV_W-1:0]  r_quo;
    logic [rrv_pkg::DVSR_W-1:0] r_rem;
    logic [rrv_pkg::DVSR_W-1:0] r_dvsr;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_done;

    logic [rrv_pkg::DVSR_W:0]   trial;
    logic [rrv_pkg::DVSR_W:0]   diff;
    logic                       ge;

    assign trial = {r_rem, r_quo[rrv_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, r_dvsr};
    assign diff  = trial - {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= CNT_W'(rrv_pkg::DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo  <= i_req.dividend;
            r_rem  <= i_req.rem_init;
            r_dvsr <= i_req.divisor;
        end else if (r_cnt != '0) begin
            // shift in the next dividend bit, keep the quotient bit
            r_quo <= {r_quo[rrv_pkg::DIV_W-2:0], ge};
            r_rem <= ge ? diff[rrv_pkg::DVSR_W-1:0] : trial[rrv_pkg::DVSR_W-1:0];
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;
endmodule

### sv/rrv_sqrt.sv
// ----------------------------------------------------------------------------
// rrv_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rrv_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrv_pkg::t_sqrt_req i_req,
    output rrv_pkg::t_sqrt_sts o_sts
);
    localparam logic [rrv_pkg::DIV_W-1:0] BIT_TOP  = {2'b01, {(rrv_pkg::DIV_W-2){1'b0}}};
    localparam logic [rrv_pkg::DIV_W-1:0] BIT_LAST = rrv_pkg::DIV_W'(1);

    logic [rrv_pkg::DIV_W-1:0] r_n;
    logic [rrv_pkg::DIV_W-1:0] r_res;
    logic [rrv_pkg::DIV_W-1:0] r_bit;
    logic                      r_busy;
    logic                      r_done;

    logic [rrv_pkg::DIV_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == BIT_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_n   <= i_req.radicand;
            r_res <= '0;
            r_bit <= BIT_TOP;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.root = r_res[rrv_pkg::DVSR_W-1:0];
endmodule

### sv/rolling_return_volatility_core.sv
// ----------------------------------------------------------------------------
// rolling_return_volatility_core
// Relative return of each price, then mean and standard deviation of the
// newest window of returns held in a ring memory.
// ----------------------------------------------------------------------------
//
//   channel    port      direction  handshake      word
//   ---------  --------  ---------  -------------  --------------------------
//   price      i_price   in         valid / ready  price, Q16.16
//   result     o_result  out        valid / ready  return, mean, vol, error
//   config     i_cfg     in         valid / ready  window_length
//
// Each price passes the serial divider three times (return, mean, variance),
// reads the ring memory one word per cycle in two passes over the newest W
// returns (W the clamped window length), then takes the square root. A zero
// price skips the arithmetic and is answered with the error word.
// After reset a clearing pass zeroes every ring word; no price
// is taken meanwhile, configuration words are.
// A stalled result waits in the output register while the next price is
// worked on; the block holds at the end of that price until the result drains.
//
module rolling_return_volatility_core #(
    parameter int RING_DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rrv_cfg_if.sink  i_cfg,
    rrv_in_if.sink   i_price,
    rrv_out_if.source o_result
);
    localparam int A_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int W_W   = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = rrv_pkg::RET_W + A_W + 1;
    localparam int ACC_W = rrv_pkg::DIV_W + A_W + 1;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_RDIV = 9'b000000100,
        S_SUM  = 9'b000001000,
        S_MDIV = 9'b000010000,
        S_VAR  = 9'b000100000,
        S_VDIV = 9'b001000000,
        S_SQRT = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state;

    // configuration and architectural state
    logic [rrv_pkg::WLEN_W-1:0]  r_wlen;
    logic [A_W-1:0]              r_wp;
    logic [rrv_pkg::PRICE_W-1:0] r_last;
    logic                        r_have;

    // ring memory
    logic [rrv_pkg::RET_W-1:0]   r_mem [RING_DEPTH];
    logic [rrv_pkg::RET_W-1:0]   r_rd_data;
    logic [A_W-1:0]              r_clr_addr;

    // per-item working registers
    logic                        r_neg;
    logic [rrv_pkg::PRICE_W-1:0] r_price;
    logic [rrv_pkg::RET_W-1:0]   r_ret;
    logic [rrv_pkg::RET_W-1:0]   r_mean;
    logic [A_W-1:0]              r_ptr;
    logic [W_W-1:0]              r_issue;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    logic signed [SUM_W-1:0]     r_sum;
    logic [rrv_pkg::DVSR_W-1:0]  r_mag;
    logic [rrv_pkg::DIV_W-1:0]   r_sq;
    logic [ACC_W-1:0]            r_acc;

    // pending result word
    logic                        r_pvol_sat;
    logic [rrv_pkg::VOL_W-1:0]   r_pvol;
    logic                        r_perr;

    // output register
    logic                             r_ovld;
    logic [rrv_pkg::RET_W-1:0]        r_oret;
    logic [rrv_pkg::RET_W-1:0]        r_omean;
    logic [rrv_pkg::VOL_W-1:0]        r_ovol;
    logic                             r_oerr;

    rrv_pkg::t_div_req  div_req;
    rrv_pkg::t_div_sts  div_sts;
    rrv_pkg::t_sqrt_req sqrt_req;
    rrv_pkg::t_sqrt_sts sqrt_sts;

    logic [W_W-1:0]              w_eff;
    logic                        in_fire;
    logic                        out_free;
    logic [rrv_pkg::PRICE_W-1:0] mag_price;
    logic [A_W-1:0]              wp_next;
    logic [A_W-1:0]              ptr_prev;
    logic [rrv_pkg::RET_W-1:0]   ret_q;
    logic [SUM_W-1:0]            sum_mag;
    logic signed [rrv_pkg::RET_W:0] dev;
    logic                        pass_idle;

    // clamp the window to 1 .. RING_DEPTH
    always_comb begin
        if (r_wlen == '0) begin
            w_eff = W_W'(1);
        end else if (32'(r_wlen) > 32'(RING_DEPTH)) begin
            w_eff = W_W'(RING_DEPTH);
        end else begin
            w_eff = W_W'(r_wlen);
        end
    end

    assign in_fire  = i_price.valid && i_price.ready;
    assign out_free = !r_ovld || o_result.ready;

    assign wp_next  = (r_wp == A_W'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign ptr_prev = (r_ptr == '0) ? A_W'(RING_DEPTH - 1) : r_ptr - 1'b1;

    // magnitude of the price move; the first price moves by nothing
    always_comb begin
        if (!r_have) begin
            mag_price = '0;
        end else if (i_price.price >= r_last) begin
            mag_price = i_price.price - r_last;
        end else begin
            mag_price = r_last - i_price.price;
        end
    end

    // signed return from the divider quotient, saturated below
    always_comb begin
        if (!r_neg) begin
            ret_q = div_sts.quotient[rrv_pkg::RET_W-1:0];
        end else if (|div_sts.quotient[rrv_pkg::DIV_W-1:rrv_pkg::RET_W-1]) begin
            ret_q = {1'b1, {(rrv_pkg::RET_W-1){1'b0}}};
        end else begin
            ret_q = '0 - div_sts.quotient[rrv_pkg::RET_W-1:0];
        end
    end

    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign dev = $signed({r_rd_data[rrv_pkg::RET_W-1], r_rd_data})
               - $signed({r_mean[rrv_pkg::RET_W-1], r_mean});
    assign pass_idle = (r_issue == '0) && !r_v1 && !r_v2 && !r_v3;

    // launch requests for the shared units
    always_comb begin
        div_req          = '0;
        sqrt_req         = '0;
        sqrt_req.radicand = div_sts.quotient;
        unique case (r_state)
            S_IDLE: begin
                div_req.start    = in_fire && (i_price.price != '0);
                div_req.dividend = {8'd0, mag_price, 24'd0};
                div_req.divisor  = i_price.price;
            end
            S_SUM: begin
                div_req.start    = pass_idle;
                div_req.dividend = rrv_pkg::DIV_W'(sum_mag);
                div_req.divisor  = rrv_pkg::DVSR_W'(w_eff);
            end
            S_VAR: begin
                div_req.start    = pass_idle;
                div_req.dividend = r_acc[rrv_pkg::DIV_W-1:0];
                div_req.rem_init = rrv_pkg::DVSR_W'(r_acc[ACC_W-1:rrv_pkg::DIV_W]);
                div_req.divisor  = rrv_pkg::DVSR_W'(w_eff);
            end
            S_VDIV: begin
                sqrt_req.start = div_sts.done;
            end
            default: begin
            end
        endcase
    end

    rrv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts)
    );

    rrv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_sts   (sqrt_sts)
    );

    // ring memory: clear sweep, return write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_state == S_RDIV && div_sts.done) begin
            r_mem[wp_next] <= ret_q;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_wlen     <= rrv_pkg::WLEN_RESET;
            r_wp       <= '0;
            r_last     <= '0;
            r_have     <= 1'b0;
            r_ovld     <= 1'b0;
            r_issue    <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_wlen <= i_cfg.window_length;
            end
            // load a new word when the slot is free, else drop a drained one
            if (r_state == S_OUT && out_free) begin
                r_ovld <= 1'b1;
            end else if (o_result.ready) begin
                r_ovld <= 1'b0;
            end

            // read pipeline of both passes
            r_v1 <= (r_state == S_SUM || r_state == S_VAR) && r_issue != '0;
            r_v2 <= (r_state == S_VAR) && r_v1;
            r_v3 <= (r_state == S_VAR) && r_v2;
            if ((r_state == S_SUM || r_state == S_VAR) && r_issue != '0) begin
                r_issue <= r_issue - 1'b1;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == A_W'(RING_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= (i_price.price == '0) ? S_OUT : S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (div_sts.done) begin
                        r_wp    <= wp_next;
                        r_last  <= r_price;
                        r_have  <= 1'b1;
                        r_issue <= w_eff;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (pass_idle) begin
                        r_state <= S_MDIV;
                    end
                end
                S_MDIV: begin
                    if (div_sts.done) begin
                        r_issue <= w_eff;
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (pass_idle) begin
                        r_state <= S_VDIV;
                    end
                end
                S_VDIV: begin
                    if (div_sts.done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_sts.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLR;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_price <= i_price.price;
                r_neg   <= r_have && (i_price.price < r_last);
                // a zero price leaves an all-zero result word with only the error code set
                r_ret      <= '0;
                r_mean     <= '0;
                r_pvol     <= '0;
                r_pvol_sat <= 1'b0;
                r_perr     <= (i_price.price == '0);
            end
            S_RDIV: begin
                r_ret <= ret_q;
                r_ptr <= wp_next;
                r_sum <= '0;
            end
            S_SUM: begin
                if (r_issue != '0) begin
                    r_ptr <= ptr_prev;
                end
                if (r_v1) begin
                    r_sum <= r_sum + SUM_W'($signed(r_rd_data));
                end
            end
            S_MDIV: begin
                r_ptr <= r_wp;
                r_acc <= '0;
                if (r_sum[SUM_W-1]) begin
                    r_mean <= '0 - div_sts.quotient[rrv_pkg::RET_W-1:0];
                end else begin
                    r_mean <= div_sts.quotient[rrv_pkg::RET_W-1:0];
                end
            end
            S_VAR: begin
                if (r_issue != '0) begin
                    r_ptr <= ptr_prev;
                end
                if (r_v1) begin
                    r_mag <= dev[rrv_pkg::RET_W] ? rrv_pkg::DVSR_W'(-dev)
                                                 : rrv_pkg::DVSR_W'(dev);
                end
                if (r_v2) begin
                    r_sq <= 64'(r_mag) * 64'(r_mag);
                end
                if (r_v3) begin
                    r_acc <= r_acc + ACC_W'(r_sq);
                end
            end
            S_SQRT: begin
                r_pvol_sat <= sqrt_sts.root[rrv_pkg::DVSR_W-1];
                r_pvol     <= sqrt_sts.root[rrv_pkg::VOL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // output register, loaded when the previous word has drained
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_oret  <= r_ret;
            r_omean <= r_mean;
            r_ovol  <= r_pvol_sat ? {rrv_pkg::VOL_W{1'b1}} : r_pvol;
            r_oerr  <= r_perr;
        end
    end

    assign i_cfg.ready   = 1'b1;
    assign i_price.ready = (r_state == S_IDLE);

    assign o_result.valid         = r_ovld;
    assign o_result.latest_return = r_oret;
    assign o_result.window_mean   = r_omean;
    assign o_result.volatility    = r_ovol;
    assign o_result.error_code    = r_oerr;
endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rolling_return_volatility_core. Prices go in
// through the price channel and each result word is compared field by field
// with a model kept here: the ring of returns, the window mean and the
// standard deviation. A short table of edge cases comes first, then random
// walks with random window lengths under three idling patterns and a long
// result back-pressure stretch.
// ----------------------------------------------------------------------------
module testbench;

    localparam int        DEPTH       = 64;
    localparam int        PHASE_ITEMS = 630;
    localparam int        BLOCK_ITEMS = 50;
    localparam int        HOLD_CYCLES = 3000;
    localparam longint    CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic signed [rrv_pkg::RET_W-1:0] ret;
        logic signed [rrv_pkg::RET_W-1:0] mean;
        logic [rrv_pkg::VOL_W-1:0]        vol;
        rrv_pkg::t_err                    err;
    } t_result;

    typedef struct packed {
        bit          is_cfg;
        logic [31:0] value;
        bit          typed;
        t_result     want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rrv_cfg_if cfg_ch();
    rrv_in_if  price_ch();
    rrv_out_if result_ch();

    rolling_return_volatility_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_price  (price_ch),
        .o_result (result_ch)
    );

    // Model state of the core
    logic [rrv_pkg::RET_W-1:0]   hist [DEPTH];
    int                          wr_pos;
    logic [rrv_pkg::PRICE_W-1:0] prev_price;
    bit                          have_prev;
    logic [rrv_pkg::WLEN_W-1:0]  win_len;

    t_result pending [$];
    int      snd_idle, rcv_idle;
    bit      hold_req;
    int      mismatches, prices_sent, results_seen, rejects_seen, cfg_writes;
    longint  cycles;

    // Directed rows; typed results only where the answer is obvious.
    localparam int N_ROWS = 24;
    t_row rows [N_ROWS] = '{
        '{1'b0, 32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, 31'd0, rrv_pkg::ERR_ZERO_PRICE}},
        '{1'b0, 32'h0001_0000, 1'b1, '{32'sd0, 32'sd0, 31'd0, rrv_pkg::ERR_NONE}},
        '{1'b0, 32'h0001_0000, 1'b1, '{32'sd0, 32'sd0, 31'd0, rrv_pkg::ERR_NONE}},
        '{1'b0, 32'h0002_0000, 1'b0, '0},
        '{1'b0, 32'h0000_0001, 1'b0, '0},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b0, 32'h8000_0000, 1'b0, '0},
        '{1'b0, 32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, 31'd0, rrv_pkg::ERR_ZERO_PRICE}},
        '{1'b0, 32'h0000_0001, 1'b0, '0},
        '{1'b0, 32'h0000_0001, 1'b0, '0},
        '{1'b1, 32'd0,         1'b0, '0},
        '{1'b0, 32'h0000_0003, 1'b0, '0},
        '{1'b0, 32'h0000_0002, 1'b0, '0},
        '{1'b1, 32'd1,         1'b0, '0},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b0, 32'h0000_0001, 1'b0, '0},
        '{1'b1, 32'd64,        1'b0, '0},
        '{1'b0, 32'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, 32'h0000_0001, 1'b0, '0},
        '{1'b1, 32'd127,       1'b0, '0},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b1, 32'd65,        1'b0, '0},
        '{1'b0, 32'h0000_8000, 1'b0, '0},
        '{1'b1, 32'd16,        1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d words outstanding",
                         cycles, pending.size());
                $display("rolling_return_volatility_core test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Model: return of one price, then mean and deviation of the window
    // ------------------------------------------------------------------
    function automatic t_result predict_price(input logic [rrv_pkg::PRICE_W-1:0] p);
        t_result                   r;
        logic [rrv_pkg::RET_W-1:0] ret;
        logic [63:0]               mag, quo, var_q, sq;
        logic [127:0]              sq_sum;
        longint signed             acc, avg, d;
        logic [31:0]               root, cand;
        int                        w, k;
        r = '0;
        if (p == 0) begin
            r.err = rrv_pkg::ERR_ZERO_PRICE;
            return r;
        end
        if (!have_prev) begin
            ret = '0;
        end else if (p >= prev_price) begin
            mag = {32'b0, p - prev_price};
            quo = (mag << 24) / {32'b0, p};
            ret = quo[31:0];
        end else begin
            mag = {32'b0, prev_price - p};
            quo = (mag << 24) / {32'b0, p};
            // Saturate a fall below -128.0
            ret = (quo >= 64'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
        end
        have_prev  = 1'b1;
        prev_price = p;
        wr_pos     = (wr_pos + 1) % DEPTH;
        hist[wr_pos] = ret;

        w = (win_len == 0) ? 1 : (win_len > DEPTH) ? DEPTH : int'(win_len);
        acc = 0;
        for (k = 0; k < w; k++)
            acc += longint'($signed(hist[(wr_pos + DEPTH - k) % DEPTH]));
        avg = acc / longint'(w);

        sq_sum = '0;
        for (k = 0; k < w; k++) begin
            d   = longint'($signed(hist[(wr_pos + DEPTH - k) % DEPTH])) - avg;
            mag = (d < 0) ? 64'(-d) : 64'(d);
            sq  = mag * mag;
            sq_sum += {64'b0, sq};
        end
        var_q = 64'(sq_sum / 128'(w));

        // Floor square root, one bit at a time from the top
        root = '0;
        for (k = 31; k >= 0; k--) begin
            cand = root | (32'd1 << k);
            if ({32'b0, cand} * {32'b0, cand} <= var_q)
                root = cand;
        end
        r.ret  = ret;
        r.mean = avg[31:0];
        r.vol  = (root > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : root[30:0];
        r.err  = rrv_pkg::ERR_NONE;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Price sender: handshake checked mid-cycle, taken at the next edge
    // ------------------------------------------------------------------
    task automatic send_price(input logic [rrv_pkg::PRICE_W-1:0] p, input bit typed,
                              input t_result want);
        bit      taken;
        t_result got;
        // Drop valid for a random gap, then offer the word
        if ($urandom_range(99) < snd_idle) begin
            price_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < snd_idle) @(posedge i_clk);
        end
        price_ch.valid <= 1'b1;
        price_ch.price <= p;
        do begin
            @(negedge i_clk);
            taken = price_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        got = predict_price(p);
        pending.push_back(typed ? want : got);
        prices_sent++;
    endtask

    // Hold until every result is back, with valid low
    task automatic drain();
        price_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [rrv_pkg::WLEN_W-1:0] wl);
        bit taken;
        drain();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.window_length <= wl;
        do begin
            @(negedge i_clk);
            taken = cfg_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        cfg_ch.valid <= 1'b0;
        win_len = wl;
        cfg_writes++;
    endtask

    function automatic logic [rrv_pkg::PRICE_W-1:0] pick_price();
        logic [rrv_pkg::PRICE_W-1:0] b, stp, p;
        int                          roll;
        roll = $urandom_range(99);
        b    = have_prev ? prev_price : 32'h0001_0000;
        if (roll < 4)
            p = '0;
        else if (roll < 10)
            p = $urandom();
        else if (roll < 12)
            p = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h1;
        else if (roll < 15)
            p = $urandom_range(32'h0100_0000, 32'h0000_1000);
        else begin
            // Random walk around the last price
            stp = b >> $urandom_range(12, 2);
            stp = $urandom_range(stp, 0);
            if ($urandom_range(1) && (b + stp > b))
                p = b + stp;
            else
                p = b - stp;
            if (p == 0) p = 32'h1;
        end
        return p;
    endfunction

    function automatic logic [rrv_pkg::WLEN_W-1:0] pick_window();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 7'd64;
            2:       return 7'd127;
            3:       return 7'($urandom_range(127));
            default: return 7'($urandom_range(10, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result receiver, with an occasional long hold-off
    // ------------------------------------------------------------------
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                result_ch.ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    initial begin
        t_result seen, want;
        bit      fire;
        forever begin
            @(negedge i_clk);
            fire = i_rst_n && result_ch.valid && result_ch.ready;
            seen = '{result_ch.latest_return, result_ch.window_mean,
                     result_ch.volatility, rrv_pkg::t_err'(result_ch.error_code)};
            @(posedge i_clk);
            if (fire) begin
                results_seen++;
                if (seen.err == rrv_pkg::ERR_ZERO_PRICE) rejects_seen++;
                if (pending.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with nothing expected: %h", $time, seen);
                end else begin
                    want = pending.pop_front();
                    if (seen.ret !== want.ret) begin
                        mismatches++;
                        $display("%0t: latest_return expected %h got %h",
                                 $time, want.ret, seen.ret);
                    end
                    if (seen.mean !== want.mean) begin
                        mismatches++;
                        $display("%0t: window_mean expected %h got %h",
                                 $time, want.mean, seen.mean);
                    end
                    if (seen.vol !== want.vol) begin
                        mismatches++;
                        $display("%0t: volatility expected %h got %h",
                                 $time, want.vol, seen.vol);
                    end
                    if (seen.err !== want.err) begin
                        mismatches++;
                        $display("%0t: error_code expected %0d got %0d",
                                 $time, want.err, seen.err);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int ph, n;
        cfg_ch.valid         = 1'b0;
        cfg_ch.window_length = rrv_pkg::WLEN_RESET;
        price_ch.valid       = 1'b0;
        price_ch.price       = '0;
        hold_req     = 1'b0;
        snd_idle     = 0;
        rcv_idle     = 0;
        mismatches   = 0;
        prices_sent  = 0;
        results_seen = 0;
        rejects_seen = 0;
        cfg_writes   = 0;
        for (int k = 0; k < DEPTH; k++) hist[k] = '0;
        wr_pos     = 0;
        prev_price = '0;
        have_prev  = 1'b0;
        win_len    = rrv_pkg::WLEN_RESET;

        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at moderate idling
        snd_idle = 20;
        rcv_idle = 20;
        for (int k = 0; k < N_ROWS; k++) begin
            if (rows[k].is_cfg)
                write_window(rows[k].value[rrv_pkg::WLEN_W-1:0]);
            else
                send_price(rows[k].value, rows[k].typed, rows[k].want);
        end

        // Random phases: sender-light, receiver-light, then no idling
        for (ph = 0; ph < 3; ph++) begin
            snd_idle = (ph == 0) ? 12 : (ph == 1) ? 52 : 0;
            rcv_idle = (ph == 0) ? 52 : (ph == 1) ? 12 : 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % BLOCK_ITEMS == 0) begin
                    write_window(pick_window());
                    // Long result stall while prices keep coming
                    if (ph == 0 && n == BLOCK_ITEMS) hold_req = 1'b1;
                end
                send_price(pick_price(), 1'b0, '0);
            end
        end
        drain();
        repeat (400) @(posedge i_clk);

        $display("ran %0d prices (%0d rejected zero prices) and %0d window writes,",
                 prices_sent, rejects_seen, cfg_writes);
        $display("checked %0d result words under three idling patterns", results_seen);
        if (mismatches == 0 && pending.size() == 0) begin
            $display("rolling_return_volatility_core test passed");
        end else begin
            $display("%0d mismatches, %0d words never came", mismatches, pending.size());
            $display("rolling_return_volatility_core test failed");
        end
        $finish;
    end

endmodule
